### rtl/alt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants for the array list table
// Payload structs, operation and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package alt_pkg;

	localparam int DEPTH_DEF = 64;   // default list capacity
	localparam int CW        = 7;    // count / position width
	localparam int IW        = 6;    // index width
	localparam int VW        = 32;   // entry width

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_DELETE  = 2'd1,
		ACT_SEARCH  = 2'd2,
		ACT_DISPLAY = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		act_t                  action;
		logic signed [VW-1:0]  value;
		logic [CW-1:0]         position;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic [IW-1:0]         index;
		logic signed [VW-1:0]  entry_value;
		logic [CW-1:0]         fill_count;
		logic                  last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic    capture;   // latch input item
		logic    init;      // set up walk pointer/remaining
		logic    walk;      // one walk step (read next, write pending on moves)
		logic    put_val;   // write new value at position, count up
		logic    drop;      // count down
		logic    emit;      // load output register
		status_t code;
		logic    use_idx;
		logic    use_val;
		logic    last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		act_t act;
		logic ins_ok;
		logic full;
		logic del_ok;
		logic empty;
		logic rem_zero;
		logic pend;
		logic hit;
		logic slot_free;
	} stat_t;

endpackage

### rtl/alt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/alt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_dp: array list datapath
// Item registers, fill count, walk pointer, entry RAM and output register.
// ----------------------------------------------------------------------------
module alt_dp #(
	parameter int DEPTH = alt_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  alt_pkg::in_item_t  in_data,
	input  alt_pkg::cmd_t      cmd,
	output alt_pkg::stat_t     stat,
	output logic               out_valid,
	input  logic               out_ready,
	output alt_pkg::out_item_t out_data
);
	import alt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	act_t                 act_q;
	logic signed [VW-1:0] val_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        ptr_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        tag_q;
	logic                 pend_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [VW-1:0]        rdata;
	logic                 mv;
	logic                 rd_en;
	logic                 wr_en;
	logic [AW-1:0]        waddr;
	logic [VW-1:0]        wdata;
	logic                 slot_free;

	assign mv        = (act_q == ACT_INSERT) || (act_q == ACT_DELETE);
	assign rd_en     = cmd.walk && (rem_q != '0);
	assign wr_en     = (cmd.walk && pend_q && mv) || cmd.put_val;
	assign waddr     = cmd.put_val ? pos_q[AW-1:0] : tag_q[AW-1:0];
	assign wdata     = cmd.put_val ? val_q : rdata;
	assign slot_free = !out_valid_q || out_ready;

	alt_ram #(
		.WIDTH(VW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_data.action;
			val_q <= in_data.value;
			pos_q <= in_data.position;
		end
	end

	// walk pointer: insert runs downward from the top entry, others upward
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			case (act_q)
				ACT_INSERT: begin
					ptr_q <= count_q - CW'(1);
					rem_q <= count_q - pos_q;
				end
				ACT_DELETE: begin
					ptr_q <= pos_q + CW'(1);
					rem_q <= count_q - pos_q - CW'(1);
				end
				default: begin
					ptr_q <= '0;
					rem_q <= count_q;
				end
			endcase
		end else if (rd_en) begin
			rem_q <= rem_q - CW'(1);
			case (act_q)
				ACT_INSERT: begin
					ptr_q <= ptr_q - CW'(1);
					tag_q <= ptr_q + CW'(1);
				end
				ACT_DELETE: begin
					ptr_q <= ptr_q + CW'(1);
					tag_q <= ptr_q - CW'(1);
				end
				default: begin
					ptr_q <= ptr_q + CW'(1);
					tag_q <= ptr_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.init) begin
				pend_q <= 1'b0;
			end else if (cmd.walk) begin
				pend_q <= rd_en;
			end
			if (cmd.put_val) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.drop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status      <= cmd.code;
			out_q.index       <= cmd.use_idx ? tag_q[IW-1:0] : '0;
			out_q.entry_value <= cmd.use_val ? rdata : '0;
			out_q.fill_count  <= count_q;
			out_q.last        <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		stat.act       = act_q;
		stat.ins_ok    = pos_q <= count_q;
		stat.full      = count_q == CW'(DEPTH);
		stat.del_ok    = pos_q < count_q;
		stat.empty     = count_q == '0;
		stat.rem_zero  = rem_q == '0;
		stat.pend      = pend_q;
		stat.hit       = pend_q && (rdata == val_q);
		stat.slot_free = slot_free;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond capacity");

	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_val |-> (count_q < CW'(DEPTH)))
		else $error("value written into a full list");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> slot_free)
		else $error("output register overwritten before transfer");

	a_move_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk && pend_q && mv) |-> (tag_q < CW'(DEPTH)))
		else $error("shift write outside the list");

endmodule

### rtl/alt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_ctrl: array list controller
// Sequences decode, shift walks, search scan, display and result transfers.
// ----------------------------------------------------------------------------
module alt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  alt_pkg::stat_t stat,
	output alt_pkg::cmd_t  cmd
);
	import alt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_MOVE   = 8'b0000_0100,
		S_FILL   = 8'b0000_1000,
		S_SCAN   = 8'b0001_0000,
		S_DREAD  = 8'b0010_0000,
		S_DEMIT  = 8'b0100_0000,
		S_RESP   = 8'b1000_0000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    found_q, found_d;

	always_comb begin
		state_d     = state_q;
		code_d      = code_q;
		found_d     = found_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.code    = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				found_d = 1'b0;
				code_d  = ST_OK;
				case (stat.act)
					ACT_INSERT: begin
						if (!stat.ins_ok) begin
							code_d  = ST_BADPOS;
							state_d = S_RESP;
						end else if (stat.full) begin
							code_d  = ST_FULL;
							state_d = S_RESP;
						end else begin
							cmd.init = 1'b1;
							state_d  = S_MOVE;
						end
					end
					ACT_DELETE: begin
						if (!stat.del_ok) begin
							code_d  = ST_BADPOS;
							state_d = S_RESP;
						end else begin
							cmd.init = 1'b1;
							state_d  = S_MOVE;
						end
					end
					ACT_SEARCH: begin
						cmd.init = 1'b1;
						state_d  = S_SCAN;
					end
					default: begin
						if (stat.empty) begin
							code_d  = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							cmd.init = 1'b1;
							state_d  = S_DREAD;
						end
					end
				endcase
			end
			S_MOVE: begin
				if (stat.rem_zero && !stat.pend) begin
					if (stat.act == ACT_INSERT) begin
						state_d = S_FILL;
					end else begin
						cmd.drop = 1'b1;
						state_d  = S_RESP;
					end
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_FILL: begin
				cmd.put_val = 1'b1;
				state_d     = S_RESP;
			end
			S_SCAN: begin
				if (stat.hit) begin
					found_d = 1'b1;
					state_d = S_RESP;
				end else if (stat.rem_zero && !stat.pend) begin
					code_d  = ST_NOTFOUND;
					state_d = S_RESP;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_DREAD: begin
				cmd.walk = 1'b1;
				state_d  = S_DEMIT;
			end
			S_DEMIT: begin
				if (stat.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.use_idx = 1'b1;
					cmd.use_val = 1'b1;
					cmd.last    = stat.rem_zero;
					if (stat.rem_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (stat.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.code    = code_q;
					cmd.use_idx = found_q;
					cmd.last    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			found_q <= found_d;
		end
	end

	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> !in_ready)
		else $error("walk step while accepting a new item");

	a_decode_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_DECODE))
		else $error("captured item not decoded");

endmodule

### rtl/array_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table: ordered list of signed 32-bit values with fill count
// Insert, delete, search and display over a single-port-walked entry RAM.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle and is finished before the
// next one is taken. A request can be rejected for a bad position, a full
// list or an empty display. The entry RAM does one read and one write per
// cycle, so a shift or scan moves one entry per clock, and a display emits
// one entry per cycle while the output register is free. A finished result
// waits in an output register; a new item can be taken while it waits, and
// the next result transfer then holds the controller until the slot frees.
// Stored entries are not cleared at reset; only the fill count is, and only
// entries below it are ever read.
// ----------------------------------------------------------------------------
module array_list_table #(
	parameter int DEPTH = alt_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  alt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output alt_pkg::out_item_t out_data
);
	import alt_pkg::*;

	cmd_t  cmd;    // controller commands
	stat_t stat;   // datapath status

	// controller: one-hot state machine, drives the walk and the transfers
	alt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: item registers, count, walk pointer, RAM, output register
	alt_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
